// ===== hdl/imhq_pkg.sv =====
// shared types and constants for the indexed min-heap queue
// no dependencies; used by imhq_cell and indexed_min_heap_queue_top
`default_nettype none

package imhq_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int HANDLE_W    = 6;
  localparam int KEY_FIELD_W = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int CMD_W       = 2;
  localparam int ERR_W       = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 48;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd3;

  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ABSENT = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DUP    = 2'd3;

  // one-cycle commands broadcast from the sequencer to every cell
  typedef struct packed {
    logic push;
    logic fill_root;
    logic fill_hit;
  } ctl_t;

  // swap requests a cell shows its parent and children
  typedef struct packed {
    logic up_swap;
    logic down_left;
    logic down_right;
  } link_t;

endpackage

`default_nettype wire

// ===== hdl/indexed_min_heap_queue_top.sv =====
// indexed min-heap queue: sequencer, result register and the row of heap cells
// depends on imhq_pkg and imhq_cell
`default_nettype none

// Usage
//   s_axis carries one command word: tuser holds the command (push, pop minimum,
//   remove by handle, peek), tdata the handle and the key. m_axis returns one
//   result word per command: minimum handle and key, entry count, empty flag
//   and error code, all after the command has taken effect.
//   The heap lives in a row of CAPACITY cells, one per slot. A sift moves one
//   level per cycle by a swap between a cell and its parent or child, and
//   handles are found by a match in every cell.
//   After a word is accepted the sequencer decides the command, waits until no
//   cell is sifting and then loads the result into the output register. The
//   input is ready again in the cycle after the result loads, and one result
//   may wait in the output register while the next command runs.
//   If the receiver stalls with a result still waiting, the sequencer holds
//   the new result and takes no further word until the register frees up.
//   Reset empties the queue, drops any waiting result and readies the input.

module indexed_min_heap_queue_top #(
  parameter int CAPACITY  = imhq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = imhq_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // handle[5:0], key[37:6], zero[39:38]
  input  wire logic [imhq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // command[1:0]
  input  wire logic [imhq_pkg::CMD_W-1:0]           s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // top_handle[5:0], top_key[37:6], entry_count[44:38], is_empty[45], error_code[47:46]
  output logic [imhq_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = imhq_pkg::HANDLE_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SIFT   = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0] state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [imhq_pkg::CMD_W-1:0] cmd_r;
  logic [HW-1:0] handle_r;
  logic signed [KEY_WIDTH-1:0] key_r;
  logic [imhq_pkg::ERR_W-1:0] err;
  logic [imhq_pkg::ERR_W-1:0] err_next;
  imhq_pkg::ctl_t ctl_next;
  imhq_pkg::ctl_t cell_ctl;

  logic [HW-1:0] cell_handle [CAPACITY];
  logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
  imhq_pkg::link_t cell_link [CAPACITY];
  logic [HW-1:0] cell_last_handle [CAPACITY];
  logic signed [KEY_WIDTH-1:0] cell_last_key [CAPACITY];
  logic [CAPACITY-1:0] cell_busy;
  logic [CAPACITY-1:0] cell_hit;

  logic busy_any;
  logic hit_any;
  logic [HW-1:0] last_handle_or;
  logic signed [KEY_WIDTH-1:0] last_key_or;
  logic [HW-1:0] last_handle;
  logic signed [KEY_WIDTH-1:0] last_key;

  logic out_free;
  logic empty;
  logic [HW-1:0] out_handle;
  logic [imhq_pkg::KEY_FIELD_W-1:0] out_key;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign busy_any      = |cell_busy;
  assign hit_any       = |cell_hit;

  // the cell at slot count-1 drives its entry, all others drive zero
  always_comb begin
    last_handle_or = '0;
    last_key_or    = '0;
    for (int n = 0; n < CAPACITY; n++) begin
      last_handle_or = last_handle_or | cell_last_handle[n];
      last_key_or    = last_key_or | cell_last_key[n];
    end
  end

  always_ff @(posedge clk) begin
    last_handle <= last_handle_or;
    last_key    <= last_key_or;
  end

  always_comb begin
    ctl_next   = '0;
    err_next   = imhq_pkg::ERR_OK;
    count_next = count;
    case (cmd_r)
      imhq_pkg::CMD_PUSH: begin
        if (count == CW'(CAPACITY)) begin
          err_next = imhq_pkg::ERR_FULL;
        end else if (hit_any) begin
          err_next = imhq_pkg::ERR_DUP;
        end else begin
          ctl_next.push = 1'b1;
          count_next    = count + CW'(1);
        end
      end
      imhq_pkg::CMD_POP: begin
        if (count == '0) begin
          err_next = imhq_pkg::ERR_ABSENT;
        end else begin
          ctl_next.fill_root = 1'b1;
          count_next         = count - CW'(1);
        end
      end
      imhq_pkg::CMD_REMOVE: begin
        if (!hit_any) begin
          err_next = imhq_pkg::ERR_ABSENT;
        end else begin
          ctl_next.fill_hit = 1'b1;
          count_next        = count - CW'(1);
        end
      end
      imhq_pkg::CMD_PEEK: begin
        err_next = imhq_pkg::ERR_OK;
      end
      default: begin
        err_next = imhq_pkg::ERR_OK;
      end
    endcase
  end

  assign cell_ctl = (state == S_DECIDE) ? ctl_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          count <= count_next;
          state <= S_SIFT;
        end
        S_SIFT: begin
          if (!busy_any) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (state == S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_r    <= s_axis_tuser;
      handle_r <= s_axis_tdata[HW-1:0];
      key_r    <= KEY_WIDTH'(s_axis_tdata[HW +: imhq_pkg::KEY_FIELD_W]);
    end
    if (state == S_DECIDE) begin
      err <= err_next;
    end
  end

  assign empty      = (count == '0);
  assign out_handle = empty ? '0 : cell_handle[0];
  assign out_key    = empty ? '0 : imhq_pkg::KEY_FIELD_W'(cell_key[0]);

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_axis_tdata <= {err, empty, imhq_pkg::COUNT_OUT_W'(count), out_key, out_handle};
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int P = (i == 0) ? 0 : (i - 1) / 2;
    localparam int L = (2 * i + 1 < CAPACITY) ? 2 * i + 1 : i;
    localparam int R = (2 * i + 2 < CAPACITY) ? 2 * i + 2 : i;

    imhq_cell #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH),
      .INDEX     (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .count         (count),
      .ctl           (cell_ctl),
      .new_handle    (handle_r),
      .new_key       (key_r),
      .fill_handle   (last_handle),
      .fill_key      (last_key),
      .probe_handle  (s_axis_tdata[HW-1:0]),
      .parent_handle (cell_handle[P]),
      .parent_key    (cell_key[P]),
      .parent_link   (cell_link[P]),
      .left_handle   (cell_handle[L]),
      .left_key      (cell_key[L]),
      .left_link     (cell_link[L]),
      .right_handle  (cell_handle[R]),
      .right_key     (cell_key[R]),
      .right_link    (cell_link[R]),
      .handle        (cell_handle[i]),
      .key           (cell_key[i]),
      .link          (cell_link[i]),
      .busy          (cell_busy[i]),
      .hit           (cell_hit[i]),
      .last_handle   (cell_last_handle[i]),
      .last_key      (cell_last_key[i])
    );
  end

`ifndef NO_ASSERTIONS
  a_single_mover : assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_busy))
    else $error("more than one heap cell active");

  a_busy_in_sift : assert property (@(posedge clk) disable iff (rst)
    busy_any |-> state == S_SIFT)
    else $error("heap cell active outside the sift phase");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_empty_flag : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[45] == (m_axis_tdata[44:38] == '0)))
    else $error("empty flag disagrees with entry count");
`endif

endmodule

`default_nettype wire

// ===== hdl/imhq_cell.sv =====
// one heap slot: holds a handle and key, swaps with its parent or a child
// depends on imhq_pkg
`default_nettype none

module imhq_cell #(
  parameter int CAPACITY  = imhq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = imhq_pkg::KEY_WIDTH_DEF,
  parameter int INDEX     = 0,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [CW-1:0]                     count,
  input  wire imhq_pkg::ctl_t                    ctl,
  input  wire logic [imhq_pkg::HANDLE_W-1:0]     new_handle,
  input  wire logic signed [KEY_WIDTH-1:0]       new_key,
  input  wire logic [imhq_pkg::HANDLE_W-1:0]     fill_handle,
  input  wire logic signed [KEY_WIDTH-1:0]       fill_key,
  input  wire logic [imhq_pkg::HANDLE_W-1:0]     probe_handle,
  input  wire logic [imhq_pkg::HANDLE_W-1:0]     parent_handle,
  input  wire logic signed [KEY_WIDTH-1:0]       parent_key,
  input  wire imhq_pkg::link_t                   parent_link,
  input  wire logic [imhq_pkg::HANDLE_W-1:0]     left_handle,
  input  wire logic signed [KEY_WIDTH-1:0]       left_key,
  input  wire imhq_pkg::link_t                   left_link,
  input  wire logic [imhq_pkg::HANDLE_W-1:0]     right_handle,
  input  wire logic signed [KEY_WIDTH-1:0]       right_key,
  input  wire imhq_pkg::link_t                   right_link,
  output logic [imhq_pkg::HANDLE_W-1:0]          handle,
  output logic signed [KEY_WIDTH-1:0]            key,
  output imhq_pkg::link_t                        link,
  output logic                                   busy,
  output logic                                   hit,
  output logic [imhq_pkg::HANDLE_W-1:0]          last_handle,
  output logic signed [KEY_WIDTH-1:0]            last_key
);

  localparam bit IS_ROOT   = (INDEX == 0);
  localparam bit IS_LEFT   = (INDEX % 2 == 1);
  localparam bit HAS_LEFT  = (2 * INDEX + 1 < CAPACITY);
  localparam bit HAS_RIGHT = (2 * INDEX + 2 < CAPACITY);
  localparam logic [CW-1:0] SELF_IDX  = CW'(INDEX);
  localparam logic [CW-1:0] LAST_CNT  = CW'(INDEX + 1);
  localparam logic [CW-1:0] LEFT_IDX  = CW'(2 * INDEX + 1);
  localparam logic [CW-1:0] RIGHT_IDX = CW'(2 * INDEX + 2);

  logic act_up;
  logic act_down;
  logic act_up_next;
  logic act_down_next;
  logic [imhq_pkg::HANDLE_W-1:0] handle_next;
  logic signed [KEY_WIDTH-1:0] key_next;

  logic valid;
  logic is_last;
  logic is_next;
  logic left_ok;
  logic right_ok;
  logic pick_right;
  logic signed [KEY_WIDTH-1:0] pick_key;
  logic swap_down;
  logic from_parent;
  logic pull_left;
  logic pull_right;
  logic fill_here;

  assign valid    = count > SELF_IDX;
  assign is_last  = count == LAST_CNT;
  assign is_next  = count == SELF_IDX;
  assign left_ok  = HAS_LEFT && (count > LEFT_IDX);
  assign right_ok = HAS_RIGHT && (count > RIGHT_IDX);

  // equal children go left
  assign pick_right = right_ok && (right_key < left_key);
  assign pick_key   = pick_right ? right_key : left_key;
  assign swap_down  = act_down && left_ok && (pick_key < key);

  assign link.up_swap    = !IS_ROOT && act_up && (key < parent_key);
  assign link.down_left  = swap_down && !pick_right;
  assign link.down_right = swap_down && pick_right;

  assign from_parent = !IS_ROOT && (IS_LEFT ? parent_link.down_left : parent_link.down_right);
  assign pull_left   = HAS_LEFT && left_link.up_swap;
  assign pull_right  = HAS_RIGHT && right_link.up_swap;
  assign fill_here   = ((ctl.fill_root && IS_ROOT) || (ctl.fill_hit && hit)) && !is_last;

  always_comb begin
    handle_next   = handle;
    key_next      = key;
    act_up_next   = act_up;
    act_down_next = act_down;
    if (ctl.push && is_next) begin
      handle_next = new_handle;
      key_next    = new_key;
      act_up_next = 1'b1;
    end else if (fill_here) begin
      handle_next = fill_handle;
      key_next    = fill_key;
      act_up_next = 1'b1;
    end else if (link.up_swap) begin
      handle_next = parent_handle;
      key_next    = parent_key;
      act_up_next = 1'b0;
    end else if (pull_left) begin
      handle_next = left_handle;
      key_next    = left_key;
      act_up_next = 1'b1;
    end else if (pull_right) begin
      handle_next = right_handle;
      key_next    = right_key;
      act_up_next = 1'b1;
    end else if (act_up) begin
      // upward walk over, check the children once
      act_up_next   = 1'b0;
      act_down_next = 1'b1;
    end else if (swap_down) begin
      handle_next   = pick_right ? right_handle : left_handle;
      key_next      = pick_right ? right_key : left_key;
      act_down_next = 1'b0;
    end else if (from_parent) begin
      handle_next   = parent_handle;
      key_next      = parent_key;
      act_down_next = 1'b1;
    end else if (act_down) begin
      act_down_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_up   <= 1'b0;
      act_down <= 1'b0;
      hit      <= 1'b0;
    end else begin
      act_up   <= act_up_next;
      act_down <= act_down_next;
      hit      <= valid && (handle == probe_handle);
    end
  end

  always_ff @(posedge clk) begin
    handle <= handle_next;
    key    <= key_next;
  end

  assign busy        = act_up | act_down;
  assign last_handle = is_last ? handle : '0;
  assign last_key    = is_last ? key : '0;

endmodule

`default_nettype wire
